>>> hw/rtl/mrf_pkg.sv
// shared types, codes and defaults for the multi-reader broadcast fifo
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

   localparam int DEPTH_DEFAULT   = 256;
   localparam int WIDTH_DEFAULT   = 32;
   localparam int READERS_DEFAULT = 4;

   localparam int QLEN_W = 9;

   // command codes
   localparam logic [2:0] CMD_ENQUEUE    = 3'd0;
   localparam logic [2:0] CMD_DEQUEUE    = 3'd1;
   localparam logic [2:0] CMD_PEEK       = 3'd2;
   localparam logic [2:0] CMD_READ_AT    = 3'd3;
   localparam logic [2:0] CMD_COUNT      = 3'd4;
   localparam logic [2:0] CMD_REGISTER   = 3'd5;
   localparam logic [2:0] CMD_UNREGISTER = 3'd6;
   localparam logic [2:0] CMD_CLEAR      = 3'd7;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_NOREADER = 3'd3;
   localparam logic [2:0] ST_NOSLOT   = 3'd4;
   localparam logic [2:0] ST_BADPOS   = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  reader_id;
      logic [7:0]  position;
      logic [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [31:0]       data_out;
      logic [QLEN_W-1:0] count;
      logic [1:0]        assigned_reader;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/mrf_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/multi_reader_fifo.sv
// top level: one-writer, multi-reader broadcast fifo with per-reader pointers
// stages: two register stages, the ram stage and then the result register;
//   a response stall holds both, and req_stall then holds off new requests
// throughput: one item per cycle while req_stall is low; the ring ram read port
//   is registered, so each item passes one ram stage and then the result register
// reset: synchronous, clears all pointers, counts and reader registrations;
//   ring contents stay undefined, no clearing pass, qlen back to min(DEPTH, 256)
`timescale 1ns / 1ps
`default_nettype none

module multi_reader_fifo
   import mrf_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEFAULT,
   parameter int WIDTH   = WIDTH_DEFAULT,
   parameter int READERS = READERS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [QLEN_W-1:0] csr_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int SUM_W = ((PTR_W > QLEN_W) ? PTR_W : QLEN_W) + 1;
   localparam int IDX_W = (READERS > 1) ? $clog2(READERS) : 1;
   localparam int QLEN_RESET = (DEPTH < 256) ? DEPTH : 256;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0]  base,
                                                 input logic [7:0]        offs,
                                                 input logic [QLEN_W-1:0] qlen);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(offs);
      if (s >= SUM_W'(qlen)) begin
         s = s - SUM_W'(qlen);
      end
      return s[PTR_W-1:0];
   endfunction

   // ring state
   logic [QLEN_W-1:0] qlen_ff, qlen_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  ptr_ff [READERS];
   logic [PTR_W-1:0]  ptr_in [READERS];
   logic [QLEN_W-1:0] cnt_ff [READERS];
   logic [QLEN_W-1:0] cnt_in [READERS];
   logic [READERS-1:0] act_ff, act_in;

   // ram stage
   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_status_ff, s1_status_in;
   logic [QLEN_W-1:0] s1_count_ff, s1_count_in;
   logic [1:0]        s1_slot_ff, s1_slot_in;
   logic              s1_rd_ff, s1_rd_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic              req_acc;
   logic              s1_adv;
   logic [31:0]       rid_wide;
   logic [IDX_W-1:0]  idx;
   logic              rid_act;
   logic [PTR_W-1:0]  cur_ptr;
   logic [QLEN_W-1:0] cur_cnt;
   logic              full;
   logic              free_found;
   logic [IDX_W-1:0]  free_idx;
   logic [QLEN_W-1:0] qlen_wr;
   logic              ram_we;
   logic              ram_re;
   logic [PTR_W-1:0]  ram_raddr;
   logic [WIDTH-1:0]  ram_wdata;
   logic [WIDTH-1:0]  ram_rdata;
   logic [63:0]       din_wide;
   logic [63:0]       dout_wide;

   assign csr_ready = 1'b1;

   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   assign rid_wide = 32'(req_data.reader_id);
   assign idx      = rid_wide[IDX_W-1:0];
   assign rid_act  = (rid_wide < 32'(READERS)) && act_ff[idx];
   assign cur_ptr  = ptr_ff[idx];
   assign cur_cnt  = cnt_ff[idx];

   assign din_wide  = 64'(req_data.data_in);
   assign ram_wdata = din_wide[WIDTH-1:0];
   assign dout_wide = 64'(ram_rdata);

   always_comb begin
      full = 1'b0;
      for (int i = 0; i < READERS; i++) begin
         if (act_ff[i] && (cnt_ff[i] >= qlen_ff)) begin
            full = 1'b1;
         end
      end
   end

   // lowest free reader slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = READERS - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (csr_data == '0) begin
         qlen_wr = QLEN_W'(1);
      end else if (32'(csr_data) > 32'(DEPTH)) begin
         qlen_wr = QLEN_W'(DEPTH);
      end else begin
         qlen_wr = csr_data;
      end
   end

   always_comb begin
      logic [31:0] slot_wide;
      qlen_in      = qlen_ff;
      wp_in        = wp_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      act_in       = act_ff;
      s1_status_in = ST_OK;
      s1_count_in  = '0;
      s1_slot_in   = '0;
      s1_rd_in     = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = cur_ptr;
      slot_wide    = 32'(free_idx);

      if (csr_valid) begin
         qlen_in = qlen_wr;
         wp_in   = '0;
         for (int i = 0; i < READERS; i++) begin
            ptr_in[i] = '0;
            cnt_in[i] = '0;
         end
      end else if (req_acc) begin
         unique case (req_data.cmd) inside
            CMD_ENQUEUE: begin
               if (full) begin
                  s1_status_in = ST_FULL;
               end else begin
                  ram_we = 1'b1;
                  wp_in  = wrap_add(wp_ff, 8'd1, qlen_ff);
                  for (int i = 0; i < READERS; i++) begin
                     if (act_ff[i]) begin
                        cnt_in[i] = cnt_ff[i] + QLEN_W'(1);
                     end
                  end
               end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
               if (!rid_act) begin
                  s1_status_in = ST_NOREADER;
               end else if (cur_cnt == '0) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  s1_rd_in = 1'b1;
                  if (req_data.cmd == CMD_DEQUEUE) begin
                     ptr_in[idx] = wrap_add(cur_ptr, 8'd1, qlen_ff);
                     cnt_in[idx] = cur_cnt - QLEN_W'(1);
                  end
               end
            end
            CMD_READ_AT: begin
               ram_raddr = wrap_add(cur_ptr, req_data.position, qlen_ff);
               if (!rid_act) begin
                  s1_status_in = ST_NOREADER;
               end else if (QLEN_W'(req_data.position) >= cur_cnt) begin
                  s1_status_in = ST_BADPOS;
               end else begin
                  s1_rd_in = 1'b1;
               end
            end
            CMD_COUNT: begin
               if (!rid_act) begin
                  s1_status_in = ST_NOREADER;
               end else begin
                  s1_count_in = cur_cnt;
               end
            end
            CMD_REGISTER: begin
               if (!free_found) begin
                  s1_status_in = ST_NOSLOT;
               end else begin
                  act_in[free_idx] = 1'b1;
                  ptr_in[free_idx] = wp_ff;
                  cnt_in[free_idx] = '0;
                  s1_slot_in       = slot_wide[1:0];
               end
            end
            CMD_UNREGISTER: begin
               if (!rid_act) begin
                  s1_status_in = ST_NOREADER;
               end else begin
                  act_in[idx] = 1'b0;
               end
            end
            CMD_CLEAR: begin
               wp_in = '0;
               for (int i = 0; i < READERS; i++) begin
                  ptr_in[i] = '0;
                  cnt_in[i] = '0;
               end
            end
         endcase
      end
   end

   assign ram_re = req_acc && s1_rd_in;

   mrf_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_valid_ff && s1_adv) begin
         rsp_valid_in           = 1'b1;
         rsp_in.status          = s1_status_ff;
         rsp_in.data_out        = s1_rd_ff ? dout_wide[31:0] : 32'd0;
         rsp_in.count           = s1_count_ff;
         rsp_in.assigned_reader = s1_slot_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff      <= QLEN_W'(QLEN_RESET);
         wp_ff        <= '0;
         act_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < READERS; i++) begin
            ptr_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         qlen_ff      <= qlen_in;
         wp_ff        <= wp_in;
         act_ff       <= act_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_status_ff <= s1_status_in;
         s1_count_ff  <= s1_count_in;
         s1_slot_ff   <= s1_slot_in;
         s1_rd_ff     <= s1_rd_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // write pointer always lies inside the ring in use
   a_wp_in_ring: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(wp_ff) < SUM_W'(qlen_ff))
      else $error("write pointer outside ring");

   // reader slot 0 never holds more unread entries than the ring length
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= qlen_ff)
      else $error("unread count exceeds ring length");

   // an accepted item always lands in the ram stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_acc && !csr_valid |=> s1_valid_ff)
      else $error("accepted item lost");

   // data is only returned for a successful read
   a_rd_status: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_rd_ff |-> s1_status_ff == ST_OK)
      else $error("read flagged with error status");

endmodule

`default_nettype wire
